FILE: src/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk once reset is released
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/dsc_pkg.sv
// Shared widths, limits and sequencer states of the divisible subarray counter
package dsc_pkg;

    localparam int unsigned MOD_W   = 11;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 48;
    localparam int unsigned EPOCH_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [MOD_W-1:0]   MOD_RESET = MOD_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_RD   = 4'b0100,
        ST_WR   = 4'b1000
    } state_t;

endpackage

FILE: src/divisible_subarray_counter.sv
// Requests are handled one at a time: the bit-serial remainder loop (33 steps,
// one quotient bit per cycle) and then one histogram read-modify-write, which
// can stall while a result waits; a new request is taken only in idle, outside a clearing pass.
// Reset: asynchronous, active low; then a histogram clearing pass over all
// MAX_MODULUS bins, repeated after every 2^8-th completed set (epoch wrap).
// The output register lets a new request be accepted while a result waits.
module divisible_subarray_counter #(
    parameter int unsigned MAX_MODULUS = 1024,
    parameter int unsigned BIN_WIDTH   = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dsc_pkg::MOD_W-1:0]     modulus,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dsc_pkg::VALUE_W-1:0]   value,
    input  logic                          last_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dsc_pkg::COUNT_W-1:0]   run_count,
    output logic                          set_done
);
    import dsc_pkg::*;

    localparam int unsigned RW    = (MAX_MODULUS > 2) ? $clog2(MAX_MODULUS) : 1;
    localparam int unsigned DW    = ((RW > VALUE_W) ? RW : VALUE_W) + 1;
    localparam int unsigned CW    = $clog2(DW);
    localparam int unsigned MW    = EPOCH_W + BIN_WIDTH;
    localparam int unsigned M_CAP = (MAX_MODULUS > (2 ** MOD_W) - 1) ?
                                    (2 ** MOD_W) - 1 : MAX_MODULUS;

    state_t                 state_reg, state_next;
    logic [MOD_W-1:0]       mod_reg, mod_next;
    logic [RW-1:0]          prefix_reg, prefix_next;
    logic [COUNT_W-1:0]     total_reg, total_next;
    logic [EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic                   clr_active_reg, clr_active_next;
    logic [RW-1:0]          clr_addr_reg, clr_addr_next;
    logic [DW-1:0]          dvd_reg, dvd_next;
    logic [MOD_W-1:0]       rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   last_reg, last_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]     run_count_reg, run_count_next;
    logic                   set_done_reg, set_done_next;

    logic [MW-1:0]          mem [MAX_MODULUS];
    logic [MW-1:0]          rd_data_reg;

    logic [MOD_W-1:0]       m_eff;
    logic [MOD_W:0]         trial;
    logic                   trial_ge;
    logic [RW-1:0]          res_idx;
    logic [BIN_WIDTH-1:0]   bin;
    logic [BIN_WIDTH-1:0]   bin_inc;
    logic [BIN_WIDTH:0]     add;
    logic [COUNT_W:0]       sum;
    logic                   in_fire;
    logic                   wr_fire;
    logic                   mem_we;
    logic [RW-1:0]          mem_waddr;
    logic [MW-1:0]          mem_wdata;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE) && !clr_active_reg;
    assign in_fire   = in_valid && in_ready;
    assign wr_fire   = (state_reg == ST_WR) && (!out_valid_reg || out_ready);

    assign out_valid = out_valid_reg;
    assign run_count = run_count_reg;
    assign set_done  = set_done_reg;

    always_comb
    begin
        if (mod_reg == '0)
        begin
            m_eff = MOD_W'(1);
        end
        else if (mod_reg > MOD_W'(M_CAP))
        begin
            m_eff = MOD_W'(M_CAP);
        end
        else
        begin
            m_eff = mod_reg;
        end
    end

    // one restoring remainder step
    assign trial    = {rem_reg, dvd_reg[DW-1]};
    assign trial_ge = trial >= {1'b0, m_eff};
    assign res_idx  = RW'(rem_reg);

    assign bin     = (rd_data_reg[BIN_WIDTH +: EPOCH_W] == epoch_reg) ?
                     rd_data_reg[BIN_WIDTH-1:0] : '0;
    assign bin_inc = (&bin) ? bin : bin + BIN_WIDTH'(1);
    assign add     = {1'b0, bin} + (BIN_WIDTH+1)'(res_idx == '0);
    assign sum     = {1'b0, total_reg} + (COUNT_W+1)'(add);

    assign mem_we    = clr_active_reg || wr_fire;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : res_idx;
    assign mem_wdata = clr_active_reg ? '0 : {epoch_reg, bin_inc};

    always_comb
    begin
        state_next      = state_reg;
        mod_next        = mod_reg;
        prefix_next     = prefix_reg;
        total_next      = total_reg;
        epoch_next      = epoch_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        last_next       = last_reg;
        out_valid_next  = out_valid_reg;
        run_count_next  = run_count_reg;
        set_done_next   = set_done_reg;

        if (cfg_valid)
        begin
            mod_next = modulus;
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + RW'(1);
            if (clr_addr_reg == RW'(MAX_MODULUS - 1))
            begin
                clr_active_next = 1'b0;
                clr_addr_next   = '0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    dvd_next   = DW'(value) + DW'(prefix_reg);
                    rem_next   = '0;
                    cnt_next   = '0;
                    last_next  = last_item;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? MOD_W'(trial - {1'b0, m_eff}) : MOD_W'(trial);
                dvd_next = {dvd_reg[DW-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (wr_fire)
                begin
                    out_valid_next = 1'b1;
                    run_count_next = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
                    set_done_next  = last_reg;
                    state_next     = ST_IDLE;
                    if (last_reg)
                    begin
                        prefix_next = '0;
                        total_next  = '0;
                        if (&epoch_reg)
                        begin
                            epoch_next      = '0;
                            clr_active_next = 1'b1;
                            clr_addr_next   = '0;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_W'(1);
                        end
                    end
                    else
                    begin
                        prefix_next = res_idx;
                        total_next  = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mod_reg        <= MOD_RESET;
            prefix_reg     <= '0;
            total_reg      <= '0;
            epoch_reg      <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mod_reg        <= mod_next;
            prefix_reg     <= prefix_next;
            total_reg      <= total_next;
            epoch_reg      <= epoch_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        last_reg      <= last_next;
        run_count_reg <= run_count_next;
        set_done_reg  <= set_done_next;
    end

    // histogram: bins tagged with the set epoch, stale tags read as zero
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD)
        begin
            rd_data_reg <= mem[res_idx];
        end
    end

endmodule

FILE: src/dsc_checker.sv
// Port-level checker for the divisible subarray counter, bound to the top level
`include "assert_macros.svh"

module dsc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [dsc_pkg::COUNT_W-1:0]   run_count,
    input  logic                          set_done
);
    import dsc_pkg::*;

    logic [1:0] pending_reg, pending_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = (&pending_reg) ? pending_reg : pending_reg + 2'd1;
        end
        else if (out_acc && !in_acc)
        begin
            pending_next = (pending_reg == 2'd0) ? pending_reg : pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `ASSERT_ALWAYS(a_no_result_in_reset, !rst_n |=> !out_valid, "result shown during reset")
    `ASSERT_CLK(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(run_count) && $stable(set_done), "stalled result changed")
    `ASSERT_CLK(a_busy_after_request, in_acc |=> !in_ready, "request taken while busy")
    `ASSERT_CLK(a_result_has_request, out_valid |-> pending_reg != 2'd0, "result without request")
    `ASSERT_CLK(a_pending_bounded, pending_reg != 2'd3, "more than two requests in flight")

endmodule

bind divisible_subarray_counter dsc_checker u_dsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .run_count (run_count),
    .set_done  (set_done)
);

FILE: dv/tb_divisible_subarray_counter.sv
// Self-checking testbench for divisible_subarray_counter: driver, monitor and run-count predictor
`timescale 1ns / 1ps

module tb_divisible_subarray_counter;

    localparam int unsigned MAX_MODULUS = 1024;
    localparam int unsigned BIN_WIDTH   = 25;
    localparam int unsigned IDLE_PCT    = 13;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 40;

    localparam logic [dsc_pkg::COUNT_W-1:0] COUNT_MAX = dsc_pkg::COUNT_MAX;
    localparam logic [BIN_WIDTH-1:0]        BIN_FULL  = {BIN_WIDTH{1'b1}};

    typedef struct {
        logic [dsc_pkg::VALUE_W-1:0] value;
        logic                        last;
    } request_t;

    typedef struct {
        logic [dsc_pkg::COUNT_W-1:0] count;
        logic                        done;
    } tally_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [dsc_pkg::MOD_W-1:0]     modulus = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [dsc_pkg::VALUE_W-1:0]   value = '0;
    logic                          last_item = 1'b0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [dsc_pkg::COUNT_W-1:0]   run_count;
    logic                          set_done;

    divisible_subarray_counter #(
        .MAX_MODULUS (MAX_MODULUS),
        .BIN_WIDTH   (BIN_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .modulus   (modulus),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .last_item (last_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .run_count (run_count),
        .set_done  (set_done)
    );

    // predictor state
    logic [dsc_pkg::MOD_W-1:0]   cfg_mod = dsc_pkg::MOD_RESET;
    int unsigned                 residue = 0;
    logic [BIN_WIDTH-1:0]        residue_bins [MAX_MODULUS];
    logic [dsc_pkg::COUNT_W-1:0] running_total = '0;

    request_t pending_requests[$];
    tally_t   expected_counts[$];
    request_t next_req;
    tally_t   want;

    logic calm = 1'b0;
    logic rx_hold = 1'b0;
    int   mismatches = 0;
    event stall_go;

    initial
    begin
        foreach (residue_bins[i])
            residue_bins[i] = '0;
    end

    function automatic int unsigned eff_mod(input logic [dsc_pkg::MOD_W-1:0] m);
        if (m == 0)
            return 1;
        if (m > MAX_MODULUS)
            return MAX_MODULUS;
        return m;
    endfunction

    function automatic void tally_item(input logic [dsc_pkg::VALUE_W-1:0] v, input logic last);
        int unsigned                 m;
        int unsigned                 r;
        logic [dsc_pkg::COUNT_W-1:0] gain;
        m = eff_mod(cfg_mod);
        r = ((residue % m) + (v % m)) % m;
        residue = r;
        gain = dsc_pkg::COUNT_W'(residue_bins[r]) + ((r == 0) ? 1 : 0);
        if (gain > COUNT_MAX - running_total)
            running_total = COUNT_MAX;
        else
            running_total = running_total + gain;
        if (residue_bins[r] != BIN_FULL)
            residue_bins[r] = residue_bins[r] + 1'b1;
        expected_counts.push_back('{running_total, last});
        if (last)
        begin
            residue = 0;
            running_total = '0;
            foreach (residue_bins[i])
                residue_bins[i] = '0;
        end
    endfunction

    function automatic void offer(input logic [dsc_pkg::VALUE_W-1:0] v, input logic last);
        pending_requests.push_back('{v, last});
    endfunction

    task automatic drain();
        wait (pending_requests.size() == 0 && !in_valid && expected_counts.size() == 0);
        @(posedge clk);
    endtask

    task automatic write_modulus(input logic [dsc_pkg::MOD_W-1:0] m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        modulus   <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_mod = m;
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            value     <= '0;
            last_item <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                tally_item(value, last_item);
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_req = pending_requests.pop_front();
                    in_valid  <= 1'b1;
                    value     <= next_req.value;
                    last_item <= next_req.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("unexpected result: run_count %0d set_done %0b", run_count, set_done);
                    mismatches++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (run_count !== want.count)
                    begin
                        $error("run_count: expected %0d, actual %0d", want.count, run_count);
                        mismatches++;
                    end
                    if (set_done !== want.done)
                    begin
                        $error("set_done: expected %0b, actual %0b", want.done, set_done);
                        mismatches++;
                    end
                end
            end
            out_ready <= !rx_hold && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // long receiver hold-off while requests keep coming
    initial
    begin
        @(stall_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #10ms;
        $display("tb_divisible_subarray_counter: errors");
        $finish;
    end

    initial
    begin
        int unsigned                m;
        int                         count;
        int                         n;
        int                         len;
        logic [dsc_pkg::MOD_W-1:0]  new_mod;
        logic [dsc_pkg::VALUE_W-1:0] v;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // modulus at its reset value
        offer(32'h0000_0000, 1'b0);
        offer(32'hFFFF_FFFF, 1'b0);
        offer(32'd5, 1'b1);
        drain();

        write_modulus(11'd3);
        offer(32'd1, 1'b0);
        offer(32'd2, 1'b0);
        offer(32'd3, 1'b0);
        offer(32'd0, 1'b0);
        offer(32'hFFFF_FFFF, 1'b1);
        offer(32'd4, 1'b0);
        offer(32'd5, 1'b0);
        drain();

        // modulus change inside an open set
        write_modulus(11'd7);
        offer(32'd6, 1'b0);
        offer(32'd1, 1'b0);
        offer(32'd13, 1'b1);
        drain();

        // zero modulus acts as one
        write_modulus(11'd0);
        offer(32'd12345, 1'b0);
        offer(32'd7, 1'b1);
        drain();

        // oversized modulus clamps to the maximum
        write_modulus(11'h7FF);
        offer(32'd1024, 1'b0);
        offer(32'd2048, 1'b0);
        offer(32'd1, 1'b0);
        offer(32'hFFFF_FFFF, 1'b1);
        drain();

        write_modulus(11'd1025);
        offer(32'd1023, 1'b0);
        offer(32'd1, 1'b1);
        drain();

        write_modulus(11'd1024);
        offer(32'h8000_0000, 1'b1);
        offer(32'd2, 1'b0);
        offer(32'h7FFF_FFFE, 1'b1);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       new_mod = 11'd0;
                1:       new_mod = 11'd1;
                2:       new_mod = 11'd1024;
                3:       new_mod = 11'h7FF;
                4:       new_mod = 11'($urandom_range(1025, 2046));
                5, 6:    new_mod = 11'($urandom_range(2, 1023));
                default: new_mod = 11'($urandom_range(2, 12));
            endcase
            write_modulus(new_mod);
            if (ph == 1)
                calm <= 1'b1;
            m = eff_mod(cfg_mod);
            count = $urandom_range(60, 66);
            n = 0;
            while (n < count)
            begin
                case ($urandom_range(0, 99))
                    0, 1:    len = $urandom_range(16, 30);
                    default: len = ($urandom_range(0, 99) < 87) ? $urandom_range(1, 2)
                                                                 : $urandom_range(3, 8);
                endcase
                for (int j = 0; j < len && n < count; j++)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: v = $urandom_range(0, 2 * m - 1);
                        5, 6:          v = m * $urandom_range(0, 1000);
                        7:             v = $urandom;
                        8:             v = 32'hFFFF_FFFF - $urandom_range(0, 3);
                        default:       v = '0;
                    endcase
                    offer(v, j == len - 1);
                    n++;
                end
            end
            if (ph == 3)
                -> stall_go;
            drain();
            calm <= 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_counts.size() == 0)
        begin
            $display("tb_divisible_subarray_counter: clean");
        end
        else
        begin
            $display("tb_divisible_subarray_counter: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/dsc_pkg.sv
src/divisible_subarray_counter.sv
src/dsc_checker.sv
dv/tb_divisible_subarray_counter.sv
